### src/lud_pkg.sv
// ----------------------------------------------------------------------------
// lud_pkg: shared types and constants for the lens undistortion block
// Beat payloads, status codes, register indexes, the divider stage record and
// the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package lud_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned COEF_BITS = 24;
   localparam int unsigned PRE_SHIFT = WORD_W - COEF_BITS;
   localparam int unsigned DIV_STEPS = WORD_W;
   localparam int unsigned PASS_W    = 7;
   localparam int unsigned TOL_W     = 31;
   localparam int unsigned IDX_W     = 3;
   localparam int unsigned STAT_W    = 2;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RESIDUAL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

   localparam logic [IDX_W-1:0] REG_K1         = 3'd0;
   localparam logic [IDX_W-1:0] REG_K2         = 3'd1;
   localparam logic [IDX_W-1:0] REG_K3         = 3'd2;
   localparam logic [IDX_W-1:0] REG_P1         = 3'd3;
   localparam logic [IDX_W-1:0] REG_P2         = 3'd4;
   localparam logic [IDX_W-1:0] REG_TOLERANCE  = 3'd5;
   localparam logic [IDX_W-1:0] REG_MAX_PASSES = 3'd6;

   localparam logic signed [63:0] SAT_MAX64 = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN64 = -64'sd2147483648;
   localparam logic signed [31:0] SAT_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN   = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] dist_x;
      logic signed [31:0] dist_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] undist_x;
      logic signed [31:0] undist_y;
      logic [STAT_W-1:0]  status;
      logic [PASS_W-1:0]  passes_used;
   } rsp_type;

   // One stage of the restoring divider: partial remainder, dividend bits not
   // yet consumed (quotient bits shift in from the bottom) and the divisor.
   typedef struct packed {
      logic        valid;
      logic [31:0] rem;
      logic [31:0] lo;
      logic [31:0] dvs;
   } div_stage_type;

   typedef struct packed {
      logic               ovf;
      logic signed [31:0] val;
   } sat_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      r.ovf = 1'b0;
      r.val = v[31:0];
      if (v > SAT_MAX64) begin
         r.ovf = 1'b1;
         r.val = SAT_MAX;
      end else if (v < SAT_MIN64) begin
         r.ovf = 1'b1;
         r.val = SAT_MIN;
      end
      return r;
   endfunction

endpackage

### src/lens_undistort_iterative.sv
// ----------------------------------------------------------------------------
// lens_undistort_iterative: iterative Brown-Conrady undistortion
// When all coefficients are zero the point goes straight out; otherwise it
// runs refinement passes, then a forward check unless a pass overflows.
// Throughput: one point at a time; a pass is bound by the 32-cell divider
// row and the single shared 32x32 multiplier. Reset is synchronous, active
// high: config registers load defaults (tolerance 2684, 10 passes).
// ----------------------------------------------------------------------------
module lens_undistort_iterative
   import lud_pkg::*;
#(
   parameter int unsigned FRAC_BITS  = 28,
   parameter int unsigned PASS_LIMIT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [WORD_W-1:0] csr_data
);

   // Rounding constants for the two product scalings and the unit radial
   // factor in Q8.24.
   localparam logic signed [63:0] RND_F    = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] RND_C    = 64'sd1 <<< (COEF_BITS - 1);
   localparam logic signed [63:0] ONE_COEF = 64'sd1 <<< COEF_BITS;
   localparam logic [PASS_W-1:0]  LIMIT    = PASS_W'(PASS_LIMIT);

   // Sequencer states, one-hot.
   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_MUL      = 9'b000000010,
      ST_POST     = 9'b000000100,
      ST_NUM      = 9'b000001000,
      ST_LAUNCH_X = 9'b000010000,
      ST_LAUNCH_Y = 9'b000100000,
      ST_WAIT     = 9'b001000000,
      ST_STEP     = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   // Multiply steps. Each one loads the product register in ST_MUL and
   // folds the product, scaled where needed, into its target in ST_POST.
   typedef enum logic [4:0] {
      OP_TOLSQ, OP_X2, OP_Y2, OP_XY, OP_A, OP_B, OP_RD, OP_T1, OP_TX,
      OP_T2, OP_TY, OP_DX, OP_DY, OP_EX, OP_EY, OP_EX2, OP_EY2
   } op_type;

   // Configuration registers.
   logic signed [31:0] k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;
   logic [TOL_W-1:0]   tol_ff;
   logic [PASS_W-1:0]  maxp_ff;

   // Sequencer and datapath registers.
   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic               fwd_ff, fwd_in;
   logic               ovf_ff, ovf_in;
   logic               got_x_ff, got_x_in;
   logic [PASS_W-1:0]  passes_ff, passes_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic signed [31:0] xd_ff, xd_in, yd_ff, yd_in;
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] x2_ff, x2_in, y2_ff, y2_in, xy_ff, xy_in, r2_ff, r2_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, rd_ff, rd_in;
   logic signed [31:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [31:0] t1_ff, t1_in, tx_ff, tx_in, ty_ff, ty_in;
   logic signed [31:0] nx_ff, nx_in, ny_ff, ny_in;
   logic signed [31:0] xn_ff, xn_in, yn_ff, yn_in;
   logic [32:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic [32:0]        ex_ff, ex_in, ey_ff, ey_in;
   logic [61:0]        tolsq_ff, tolsq_in;
   logic [61:0]        e1_ff, e1_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic signed [31:0] opa, opb;
   logic signed [63:0] mul_f, mul_c;
   sat_type            sat_mf, sat_a, sat_b, sat_rd, sat_r2, sat_sx, sat_sy;
   sat_type            sat_mc, sat_2mc, sat_tx, sat_ty, sat_ex, sat_ey;
   sat_type            sat_nx, sat_ny;
   logic signed [32:0] ex_diff, ey_diff, dx_diff, dy_diff;
   logic [32:0]        ex_abs, ey_abs, dx_abs, dy_abs;
   logic [62:0]        sq_sum;
   logic [PASS_W-1:0]  budget;
   logic [PASS_W-1:0]  passes_next;
   logic               coef_zero;
   logic               req_fire;

   // Divider launch and result.
   div_stage_type      div_head, div_tail;
   logic signed [31:0] launch_num;
   logic [31:0]        launch_abs;
   logic [31:0]        rd_abs;
   logic signed [31:0] res_num;
   logic [31:0]        res_abs;
   logic               res_big;
   logic               res_neg;
   sat_type            div_res;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign coef_zero = (k1_ff == '0) && (k2_ff == '0) && (k3_ff == '0) &&
                      (p1_ff == '0) && (p2_ff == '0);
   assign budget      = (maxp_ff > LIMIT) ? LIMIT : maxp_ff;
   assign passes_next = passes_ff + 1'b1;

   // Configuration writes. Indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff   <= '0;
         k2_ff   <= '0;
         k3_ff   <= '0;
         p1_ff   <= '0;
         p2_ff   <= '0;
         tol_ff  <= TOL_W'(2684);
         maxp_ff <= PASS_W'(10);
      end else if (csr_valid) begin
         case (csr_index)
            REG_K1:         k1_ff   <= signed'(csr_data);
            REG_K2:         k2_ff   <= signed'(csr_data);
            REG_K3:         k3_ff   <= signed'(csr_data);
            REG_P1:         p1_ff   <= signed'(csr_data);
            REG_P2:         p2_ff   <= signed'(csr_data);
            REG_TOLERANCE:  tol_ff  <= csr_data[TOL_W-1:0];
            REG_MAX_PASSES: maxp_ff <= csr_data[PASS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Shared multiplier operand selection. The product register sits between
   // this multiplier and all the rounding, adding and saturating after it.
   always_comb begin
      opa = x_ff;
      opb = x_ff;
      case (op_ff)
         OP_TOLSQ: begin
            opa = signed'({1'b0, tol_ff});
            opb = signed'({1'b0, tol_ff});
         end
         OP_X2: begin
            opa = x_ff;
            opb = x_ff;
         end
         OP_Y2: begin
            opa = y_ff;
            opb = y_ff;
         end
         OP_XY: begin
            opa = x_ff;
            opb = y_ff;
         end
         OP_A: begin
            opa = r2_ff;
            opb = k3_ff;
         end
         OP_B: begin
            opa = r2_ff;
            opb = a_ff;
         end
         OP_RD: begin
            opa = r2_ff;
            opb = b_ff;
         end
         OP_T1: begin
            opa = p1_ff;
            opb = xy_ff;
         end
         OP_TX: begin
            opa = p2_ff;
            opb = sx_ff;
         end
         OP_T2: begin
            opa = p1_ff;
            opb = sy_ff;
         end
         OP_TY: begin
            opa = p2_ff;
            opb = xy_ff;
         end
         OP_DX: begin
            opa = signed'(dx_ff[31:0]);
            opb = signed'(dx_ff[31:0]);
         end
         OP_DY: begin
            opa = signed'(dy_ff[31:0]);
            opb = signed'(dy_ff[31:0]);
         end
         OP_EX: begin
            opa = x_ff;
            opb = rd_ff;
         end
         OP_EY: begin
            opa = y_ff;
            opb = rd_ff;
         end
         OP_EX2: begin
            opa = signed'(ex_ff[31:0]);
            opb = signed'(ex_ff[31:0]);
         end
         OP_EY2: begin
            opa = signed'(ey_ff[31:0]);
            opb = signed'(ey_ff[31:0]);
         end
         default: begin
         end
      endcase
   end

   assign prod_in = 64'(opa) * 64'(opb);

   // Products rounded to nearest, ties up, in either scaling.
   assign mul_f = (prod_ff + RND_F) >>> FRAC_BITS;
   assign mul_c = (prod_ff + RND_C) >>> COEF_BITS;

   assign sat_mf  = sat32(mul_f);
   assign sat_a   = sat32(64'(k2_ff) + mul_f);
   assign sat_b   = sat32(64'(k1_ff) + mul_f);
   assign sat_rd  = sat32(ONE_COEF + mul_f);
   assign sat_r2  = sat32(64'(x2_ff) + 64'(y2_ff));
   assign sat_sx  = sat32(64'(r2_ff) + (64'(x2_ff) <<< 1));
   assign sat_sy  = sat32(64'(r2_ff) + (64'(y2_ff) <<< 1));
   assign sat_mc  = sat32(mul_c);
   assign sat_2mc = sat32(mul_c <<< 1);
   assign sat_tx  = sat32(64'(t1_ff) + 64'(signed'(sat_mc.val)));
   assign sat_ty  = sat32(64'(t1_ff) + 64'(signed'(sat_2mc.val)));
   assign sat_ex  = sat32(64'(signed'(sat_mc.val)) + 64'(tx_ff));
   assign sat_ey  = sat32(64'(signed'(sat_mc.val)) + 64'(ty_ff));
   assign sat_nx  = sat32(64'(xd_ff) - 64'(tx_ff));
   assign sat_ny  = sat32(64'(yd_ff) - 64'(ty_ff));

   // Residual of the forward check and step of a pass, as magnitudes.
   assign ex_diff = 33'(signed'(sat_ex.val)) - 33'(xd_ff);
   assign ey_diff = 33'(signed'(sat_ey.val)) - 33'(yd_ff);
   assign ex_abs  = ex_diff[32] ? 33'(-ex_diff) : 33'(ex_diff);
   assign ey_abs  = ey_diff[32] ? 33'(-ey_diff) : 33'(ey_diff);
   assign dx_diff = 33'(xn_ff) - 33'(x_ff);
   assign dy_diff = 33'(yn_ff) - 33'(y_ff);
   assign dx_abs  = dx_diff[32] ? 33'(-dx_diff) : 33'(dx_diff);
   assign dy_abs  = dy_diff[32] ? 33'(-dy_diff) : 33'(dy_diff);

   assign sq_sum = 63'(e1_ff) + 63'(prod_ff[61:0]);

   // Divider launch: the dividend is |num| * 2^24, split so that its upper
   // part starts the remainder and its lower 32 bits are consumed bit by bit.
   assign rd_abs     = rd_ff[31] ? 32'(-rd_ff) : 32'(rd_ff);
   assign launch_num = (state_ff == ST_LAUNCH_Y) ? ny_ff : nx_ff;
   assign launch_abs = launch_num[31] ? 32'(-launch_num) : 32'(launch_num);

   always_comb begin
      div_head.valid = (state_ff == ST_LAUNCH_X) || (state_ff == ST_LAUNCH_Y);
      div_head.rem   = launch_abs >> PRE_SHIFT;
      div_head.lo    = launch_abs << COEF_BITS;
      div_head.dvs   = rd_abs;
   end

   lud_div_chain u_div_chain (
      .clock (clock),
      .reset (reset),
      .head  (div_head),
      .tail  (div_tail)
   );

   // Quotient sign, saturation and the zero divisor case. The x result
   // leaves the row first, the y result in the next cycle.
   assign res_num = got_x_ff ? ny_ff : nx_ff;
   assign res_abs = res_num[31] ? 32'(-res_num) : 32'(res_num);
   assign res_big = (res_abs >> PRE_SHIFT) >= rd_abs;
   assign res_neg = res_num[31] ^ rd_ff[31];

   always_comb begin
      div_res.ovf = 1'b0;
      div_res.val = signed'(div_tail.lo);
      if (rd_ff == '0) begin
         div_res.ovf = 1'b1;
         div_res.val = res_num[31] ? SAT_MIN : SAT_MAX;
      end else if (res_big) begin
         div_res.ovf = 1'b1;
         div_res.val = res_neg ? SAT_MIN : SAT_MAX;
      end else if (!res_neg) begin
         if (div_tail.lo[31]) begin
            div_res.ovf = 1'b1;
            div_res.val = SAT_MAX;
         end
      end else begin
         if (div_tail.lo > 32'h8000_0000) begin
            div_res.ovf = 1'b1;
            div_res.val = SAT_MIN;
         end else begin
            div_res.val = signed'(32'(-div_tail.lo));
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      fwd_in       = fwd_ff;
      ovf_in       = ovf_ff;
      got_x_in     = got_x_ff;
      passes_in    = passes_ff;
      status_in    = status_ff;
      xd_in        = xd_ff;
      yd_in        = yd_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      xy_in        = xy_ff;
      r2_in        = r2_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rd_in        = rd_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      t1_in        = t1_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      xn_in        = xn_ff;
      yn_in        = yn_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      tolsq_in     = tolsq_ff;
      e1_in        = e1_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               xd_in     = req_data.dist_x;
               yd_in     = req_data.dist_y;
               x_in      = req_data.dist_x;
               y_in      = req_data.dist_y;
               passes_in = '0;
               ovf_in    = 1'b0;
               fwd_in    = 1'b0;
               status_in = STAT_OK;
               op_in     = OP_TOLSQ;
               // With no distortion terms the point goes straight out.
               state_in  = coef_zero ? ST_DONE : ST_MUL;
            end
         end

         ST_MUL: begin
            state_in = ST_POST;
         end

         ST_POST: begin
            state_in = ST_MUL;
            case (op_ff)
               OP_TOLSQ: begin
                  tolsq_in = prod_ff[61:0];
                  // An empty pass budget checks the input point itself.
                  fwd_in   = (budget == '0);
                  op_in    = OP_X2;
               end
               OP_X2: begin
                  x2_in  = sat_mf.val;
                  ovf_in = ovf_ff | sat_mf.ovf;
                  op_in  = OP_Y2;
               end
               OP_Y2: begin
                  y2_in  = sat_mf.val;
                  ovf_in = ovf_ff | sat_mf.ovf;
                  op_in  = OP_XY;
               end
               OP_XY: begin
                  xy_in  = sat_mf.val;
                  r2_in  = sat_r2.val;
                  ovf_in = ovf_ff | sat_mf.ovf | sat_r2.ovf;
                  op_in  = OP_A;
               end
               OP_A: begin
                  a_in   = sat_a.val;
                  ovf_in = ovf_ff | sat_a.ovf;
                  op_in  = OP_B;
               end
               OP_B: begin
                  b_in   = sat_b.val;
                  ovf_in = ovf_ff | sat_b.ovf;
                  op_in  = OP_RD;
               end
               OP_RD: begin
                  rd_in  = sat_rd.val;
                  sx_in  = sat_sx.val;
                  sy_in  = sat_sy.val;
                  ovf_in = ovf_ff | sat_rd.ovf | sat_sx.ovf | sat_sy.ovf;
                  op_in  = OP_T1;
               end
               OP_T1: begin
                  t1_in  = sat_2mc.val;
                  ovf_in = ovf_ff | sat_2mc.ovf;
                  op_in  = OP_TX;
               end
               OP_TX: begin
                  tx_in  = sat_tx.val;
                  ovf_in = ovf_ff | sat_mc.ovf | sat_tx.ovf;
                  op_in  = OP_T2;
               end
               OP_T2: begin
                  t1_in  = sat_mc.val;
                  ovf_in = ovf_ff | sat_mc.ovf;
                  op_in  = OP_TY;
               end
               OP_TY: begin
                  ty_in  = sat_ty.val;
                  ovf_in = ovf_ff | sat_2mc.ovf | sat_ty.ovf;
                  if (fwd_ff) begin
                     op_in = OP_EX;
                  end else begin
                     state_in = ST_NUM;
                  end
               end
               OP_DX: begin
                  e1_in = prod_ff[61:0];
                  op_in = OP_DY;
               end
               OP_DY: begin
                  op_in = OP_X2;
                  // A small enough step or a spent budget ends the loop.
                  if (sq_sum < 63'(tolsq_ff) || passes_ff >= budget) begin
                     fwd_in = 1'b1;
                  end
               end
               OP_EX: begin
                  ex_in  = ex_abs;
                  ovf_in = ovf_ff | sat_mc.ovf | sat_ex.ovf;
                  op_in  = OP_EY;
               end
               OP_EY: begin
                  ey_in = ey_abs;
                  if (ovf_ff | sat_mc.ovf | sat_ey.ovf) begin
                     status_in = STAT_OVERFLOW;
                     state_in  = ST_DONE;
                  end else if (ex_ff > {2'b00, tol_ff} || ey_abs > {2'b00, tol_ff}) begin
                     status_in = STAT_RESIDUAL;
                     state_in  = ST_DONE;
                  end else begin
                     op_in = OP_EX2;
                  end
               end
               OP_EX2: begin
                  e1_in = prod_ff[61:0];
                  op_in = OP_EY2;
               end
               OP_EY2: begin
                  status_in = (sq_sum > 63'(tolsq_ff)) ? STAT_RESIDUAL : STAT_OK;
                  state_in  = ST_DONE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_NUM: begin
            nx_in    = sat_nx.val;
            ny_in    = sat_ny.val;
            ovf_in   = ovf_ff | sat_nx.ovf | sat_ny.ovf;
            state_in = ST_LAUNCH_X;
         end

         ST_LAUNCH_X: begin
            got_x_in = 1'b0;
            state_in = ST_LAUNCH_Y;
         end

         ST_LAUNCH_Y: begin
            state_in = ST_WAIT;
         end

         ST_WAIT: begin
            if (div_tail.valid) begin
               ovf_in = ovf_ff | div_res.ovf;
               if (!got_x_ff) begin
                  xn_in    = div_res.val;
                  got_x_in = 1'b1;
               end else begin
                  yn_in    = div_res.val;
                  state_in = ST_STEP;
               end
            end
         end

         ST_STEP: begin
            x_in      = xn_ff;
            y_in      = yn_ff;
            dx_in     = dx_abs;
            dy_in     = dy_abs;
            passes_in = passes_next;
            if (ovf_ff) begin
               // An overflow inside a pass skips the forward check.
               status_in = STAT_OVERFLOW;
               state_in  = ST_DONE;
            end else if (dx_abs[32:31] != 2'b00 || dy_abs[32:31] != 2'b00) begin
               // A step this large can never pass the tolerance test.
               state_in = ST_MUL;
               op_in    = OP_X2;
               fwd_in   = (passes_next >= budget);
            end else begin
               state_in = ST_MUL;
               op_in    = OP_DX;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.undist_x     = x_ff;
               rsp_data_in.undist_y     = y_ff;
               rsp_data_in.status       = status_ff;
               rsp_data_in.passes_used  = passes_ff;
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      fwd_ff      <= fwd_in;
      ovf_ff      <= ovf_in;
      got_x_ff    <= got_x_in;
      passes_ff   <= passes_in;
      status_ff   <= status_in;
      xd_ff       <= xd_in;
      yd_ff       <= yd_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      x2_ff       <= x2_in;
      y2_ff       <= y2_in;
      xy_ff       <= xy_in;
      r2_ff       <= r2_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      rd_ff       <= rd_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      t1_ff       <= t1_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      xn_ff       <= xn_in;
      yn_ff       <= yn_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      tolsq_ff    <= tolsq_in;
      e1_ff       <= e1_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### src/lud_div_cell.sv
// ----------------------------------------------------------------------------
// lud_div_cell: one restoring division step
// Shifts one dividend bit into the remainder, subtracts the divisor when it
// fits and registers the result for the next cell.
// ----------------------------------------------------------------------------
module lud_div_cell
   import lud_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  div_stage_type prev_stage,
   output div_stage_type next_stage
);

   div_stage_type stage_ff, stage_in;
   logic [32:0]   trial;
   logic [32:0]   diff;
   logic          take;

   always_comb begin
      trial = {prev_stage.rem, prev_stage.lo[31]};
      diff  = trial - {1'b0, prev_stage.dvs};
      take  = ~diff[32];
      stage_in.valid = prev_stage.valid;
      stage_in.dvs   = prev_stage.dvs;
      stage_in.rem   = take ? diff[31:0] : trial[31:0];
      stage_in.lo    = {prev_stage.lo[30:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.rem <= stage_in.rem;
      stage_ff.lo  <= stage_in.lo;
      stage_ff.dvs <= stage_in.dvs;
   end

   assign next_stage = stage_ff;

endmodule

### src/lud_div_chain.sv
// ----------------------------------------------------------------------------
// lud_div_chain: row of division cells
// One quotient bit per cell; a new division may enter every cycle and leaves
// the last cell with its 32-bit magnitude quotient.
// ----------------------------------------------------------------------------
module lud_div_chain
   import lud_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  div_stage_type head,
   output div_stage_type tail
);

   div_stage_type link [0:DIV_STEPS];

   assign link[0] = head;

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
      lud_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_stage (link[g]),
         .next_stage (link[g+1])
      );
   end

   assign tail = link[DIV_STEPS];

endmodule
